@@ rtl/swppm_pkg.sv @@
`default_nettype none
// ============================================================================
// Sliding-window peak-to-peak package
// Widths and types shared by the block, its checker and the testbench.
// ============================================================================
package swppm_pkg;

    localparam int unsigned SAMPLE_W   = 32;  // width of one sample
    localparam int unsigned SPREAD_W   = 33;  // signed result width
    localparam int unsigned CFG_W      = 7;   // window length register width
    localparam int unsigned M_TDATA_W  = 40;  // result beat, padded to bytes
    localparam int unsigned S_TDATA_W  = 32;  // sample beat

    typedef logic [SAMPLE_W-1:0]        t_sample;
    typedef logic signed [SPREAD_W-1:0] t_spread;
    typedef logic [CFG_W-1:0]           t_cfg;

    // All ones: the result shown when no full window was seen.
    localparam t_spread SPREAD_NONE = '1;

endpackage : swppm_pkg
`default_nettype wire

@@ rtl/swppm_ram.sv @@
`default_nettype none
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ============================================================================
module swppm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule : swppm_ram
`default_nettype wire

@@ rtl/sliding_window_peak_to_peak_max.sv @@
`default_nettype none
// ============================================================================
// Sliding-window peak-to-peak maximum
// Tracks the largest max-minus-min spread over a sliding window of samples.
// ============================================================================
// Samples arrive one per beat on the slave stream, with tlast on the final
// sample of a sequence. Each sample is written into a circular window RAM, and
// once the sequence holds at least a window's worth of samples the block reads
// back the newest window, one entry per cycle, through a single max/min
// comparator pair. The spread of that window is folded into a running best.
// On the sample carrying tlast one result beat is sent on the master stream:
// the best spread, or -1 (all 33 bits set) if no full window occurred, after
// which the sequence state clears. A sample occupies the block from its
// acceptance through S_SCAN, S_DRAIN and S_FIN when a window is evaluated
// and through S_FIN alone otherwise; S_FIN holds for as long as a result is
// due while the previous one has not yet been taken. The window length
// register reads zero as one and is clamped to WINDOW_DEPTH; it is written
// on the configuration channel, which is always ready, and should only
// change while the block is idle.
// ============================================================================
module sliding_window_peak_to_peak_max #(
    parameter int unsigned WINDOW_DEPTH = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Sample stream
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [swppm_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [31:0] sample
    input  wire logic                       s_axis_tlast,       // is_last
    // Result stream
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [swppm_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [32:0] best_spread, zero pad
    // Configuration channel: window length
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [swppm_pkg::CFG_W-1:0] i_cfg_data         // [6:0] window_length
);

    import swppm_pkg::*;

    localparam int unsigned ADDR_W = $clog2(WINDOW_DEPTH);
    localparam int unsigned LEN_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned CMP_W  = (LEN_W > CFG_W) ? LEN_W : CFG_W;

    // Sequencer state codes.
    localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for a sample
    localparam logic [1:0] S_SCAN  = 2'd1;  // issuing window reads
    localparam logic [1:0] S_DRAIN = 2'd2;  // last read data arriving
    localparam logic [1:0] S_FIN   = 2'd3;  // fold spread, maybe emit result

    logic [1:0]        r_state, n_state;
    t_cfg              r_wlen;
    logic [ADDR_W-1:0] r_wslot, n_wslot;
    logic [LEN_W-1:0]  r_seen, n_seen;
    t_spread           r_best, n_best;
    logic [ADDR_W-1:0] r_rd_addr, n_rd_addr;
    logic [LEN_W-1:0]  r_left, n_left;
    logic              r_do, n_do;
    logic              r_last, n_last;
    logic              r_rd_vld;
    t_sample           r_hi, n_hi;
    t_sample           r_lo, n_lo;
    logic              r_out_vld, n_out_vld;
    t_spread           r_out, n_out;

    logic              s_accept;
    logic              rd_en;
    t_sample           rd_data;
    logic [CMP_W-1:0]  wlen_ext;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  seen_inc;
    t_sample           spread;
    t_spread           best_upd;
    logic              out_free;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign rd_en         = (r_state == S_SCAN);

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(M_TDATA_W - SPREAD_W){1'b0}}, r_out};

    // Effective window length: zero reads as one, clamp to the store depth.
    assign wlen_ext = CMP_W'(r_wlen);
    always_comb begin
        if (wlen_ext == '0) begin
            eff_len = LEN_W'(1);
        end else if (wlen_ext > CMP_W'(WINDOW_DEPTH)) begin
            eff_len = LEN_W'(WINDOW_DEPTH);
        end else begin
            eff_len = LEN_W'(wlen_ext);
        end
    end

    assign seen_inc = (r_seen == LEN_W'(WINDOW_DEPTH)) ? r_seen : r_seen + LEN_W'(1);

    // Spread of the window just scanned, folded into the running best.
    assign spread   = r_hi - r_lo;
    assign best_upd = (r_do && ($signed({1'b0, spread}) > r_best))
                      ? t_spread'({1'b0, spread}) : r_best;
    assign out_free = !r_out_vld || m_axis_tready;

    swppm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s_accept),
        .i_wr_addr (r_wslot),
        .i_wr_data (s_axis_tdata[SAMPLE_W-1:0]),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state   = r_state;
        n_wslot   = r_wslot;
        n_seen    = r_seen;
        n_best    = r_best;
        n_rd_addr = r_rd_addr;
        n_left    = r_left;
        n_do      = r_do;
        n_last    = r_last;
        n_hi      = r_hi;
        n_lo      = r_lo;
        n_out     = r_out;
        n_out_vld = r_out_vld && !m_axis_tready;

        // The comparator pair takes one RAM word per cycle.
        if (r_rd_vld) begin
            if (rd_data > r_hi) begin
                n_hi = rd_data;
            end
            if (rd_data < r_lo) begin
                n_lo = rd_data;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    // The scan starts at the slot being written and walks back.
                    n_rd_addr = r_wslot;
                    n_wslot   = (r_wslot == ADDR_W'(WINDOW_DEPTH - 1))
                                ? '0 : r_wslot + ADDR_W'(1);
                    n_seen    = seen_inc;
                    n_left    = eff_len;
                    n_do      = (seen_inc >= eff_len);
                    n_last    = s_axis_tlast;
                    n_hi      = '0;
                    n_lo      = '1;
                    n_state   = (seen_inc >= eff_len) ? S_SCAN : S_FIN;
                end
            end
            S_SCAN: begin
                n_rd_addr = (r_rd_addr == '0)
                            ? ADDR_W'(WINDOW_DEPTH - 1) : r_rd_addr - ADDR_W'(1);
                n_left    = r_left - LEN_W'(1);
                if (r_left == LEN_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_last) begin
                    n_best  = best_upd;
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out     = best_upd;
                    n_out_vld = 1'b1;
                    n_best    = SPREAD_NONE;
                    n_wslot   = '0;
                    n_seen    = '0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wlen    <= t_cfg'(1);
            r_wslot   <= '0;
            r_seen    <= '0;
            r_best    <= SPREAD_NONE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wslot   <= n_wslot;
            r_seen    <= n_seen;
            r_best    <= n_best;
            r_rd_vld  <= rd_en;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_wlen <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
        r_left    <= n_left;
        r_do      <= n_do;
        r_last    <= n_last;
        r_hi      <= n_hi;
        r_lo      <= n_lo;
        r_out     <= n_out;
    end

endmodule : sliding_window_peak_to_peak_max
`default_nettype wire

@@ rtl/swppm_checker.sv @@
`default_nettype none
// ============================================================================
// Sliding-window peak-to-peak port checker
// Watches the top level's ports and flags behaviour the block must not show.
// ============================================================================
module swppm_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    input  wire logic                            s_axis_tready,
    input  wire logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic [swppm_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import swppm_pkg::*;

    // No result beat is offered straight after reset.
    a_reset_quiet : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat offered after reset");

    // A result beat stays offered until it is taken.
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    // Each accepted sample leaves the sample stream not ready in the cycle after it.
    a_busy_after_beat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("sample stream ready straight after a beat");

    // A result is a non-negative spread or exactly minus one, with zero padding.
    a_result_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1:SPREAD_W] == '0) &&
            (!m_axis_tdata[SPREAD_W-1] ||
             (m_axis_tdata[SPREAD_W-1:0] == SPREAD_NONE)))
        else $error("result beat outside the spread range");

endmodule : swppm_checker

bind sliding_window_peak_to_peak_max swppm_checker u_swppm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

@@ tb/tb_top.sv @@
// ============================================================================
// Sliding-window peak-to-peak maximum testbench
// Streams sample sequences through the block under several window lengths,
// predicts the best max-minus-min spread of each sequence and checks every
// result beat against the prediction, with random gaps and stalls on both
// streams.
// ============================================================================
module tb_top;
    import swppm_pkg::*;

    localparam int unsigned WINDOW_DEPTH  = 64;
    // The longest a sample can keep the block busy, with some slack: a full
    // window scan plus the pipeline and result hand-off cycles.
    localparam int unsigned SETTLE_CYCLES = WINDOW_DEPTH + 16;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned RANDOM_ITEMS  = 450;
    localparam int unsigned RANDOM_SEQS   = 10;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    wire                  s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;   // [31:0] sample
    logic                 s_axis_tlast  = 1'b0; // is_last
    wire                  m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    wire  [M_TDATA_W-1:0] m_axis_tdata;         // [32:0] best_spread, [39:33] zero pad
    logic                 i_cfg_valid   = 1'b0;
    wire                  o_cfg_ready;
    logic [CFG_W-1:0]     i_cfg_data    = '0;   // [6:0] window_length

    // ------------------------------------------------------------------------
    // Spread tracker: mirrors the window store and the running best spread of
    // the block, queues the spread due on each sequence end and checks each
    // result beat against the oldest one.
    // ------------------------------------------------------------------------
    class spread_tracker;
        t_sample     ring [WINDOW_DEPTH];
        int unsigned slot;
        int unsigned seen;
        t_spread     best;
        t_cfg        win_len;
        t_spread     expected_spreads [$];
        int unsigned errors;

        function new();
            win_len = 1;
            errors  = 0;
            clear_sequence();
        endfunction

        function void clear_sequence();
            slot = 0;
            seen = 0;
            best = SPREAD_NONE;
        endfunction

        function void note_config(t_cfg value);
            win_len = value;
        endfunction

        function void note_sample(t_sample value, logic last);
            int unsigned len;
            int unsigned pos;
            t_sample     hi;
            t_sample     lo;
            t_spread     spread;
            // A zero length behaves as one; anything beyond the store is clamped.
            len = (win_len == 0) ? 1 : ((win_len > WINDOW_DEPTH) ? WINDOW_DEPTH : win_len);
            ring[slot] = value;
            slot = (slot + 1 == WINDOW_DEPTH) ? 0 : slot + 1;
            if (seen < WINDOW_DEPTH) begin
                seen++;
            end
            if (seen >= len) begin
                hi  = '0;
                lo  = '1;
                pos = slot;
                for (int k = 0; k < len; k++) begin
                    pos = (pos == 0) ? WINDOW_DEPTH - 1 : pos - 1;
                    if (ring[pos] > hi) begin
                        hi = ring[pos];
                    end
                    if (ring[pos] < lo) begin
                        lo = ring[pos];
                    end
                end
                spread = t_spread'({1'b0, hi - lo});
                if (spread > best) begin
                    best = spread;
                end
            end
            if (last) begin
                expected_spreads = {expected_spreads, best};
                clear_sequence();
            end
        endfunction

        function int unsigned pending();
            return expected_spreads.size();
        endfunction

        function void check_beat(logic [M_TDATA_W-1:0] beat);
            logic [M_TDATA_W-1:0] want;
            if (expected_spreads.size() == 0) begin
                errors++;
                $display("%0t: result beat with none expected, expected none, actual %h",
                         $time, beat);
                return;
            end
            // The padding above the spread must read as zero as well.
            want = {{(M_TDATA_W - SPREAD_W){1'b0}}, expected_spreads.pop_front()};
            if (beat !== want) begin
                errors++;
                $display("%0t: best_spread mismatch, expected %h, actual %h",
                         $time, want, beat);
            end
        endfunction
    endclass

    spread_tracker spreads = new();

    sliding_window_peak_to_peak_max #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // A hung handshake or a missing result ends the run here.
    int unsigned cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: every accepted beat is checked, and tready follows its own
    // pattern of steady acceptance, coin-flip acceptance and short stalls.
    // Values read straight after the edge are the ones the block saw there.
    // ------------------------------------------------------------------------
    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            spreads.check_beat(m_axis_tdata);
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = (stall_mode == 2) ? $urandom_range(1, 12) : $urandom_range(1, 40);
        end
        stall_left--;
        case (stall_mode)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_axis_tready <= 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Sample side. The sender works in bursts; a burst ending may leave a gap
    // before the next one. Valid is only lowered where a gap really follows,
    // so it is never dropped and raised again within one step.
    // ------------------------------------------------------------------------
    int unsigned burst_left   = 0;
    int unsigned gap_due      = 0;
    int unsigned sent_samples = 0;
    int unsigned sent_lasts   = 0;
    int unsigned samples_base = 0;
    int unsigned lasts_base   = 0;

    task automatic push_sample(t_sample value, logic last);
        repeat (gap_due) @(posedge i_clk);
        gap_due = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        spreads.note_sample(value, last);
        sent_samples++;
        if (last) begin
            sent_lasts++;
        end
        burst_left--;
        if (burst_left == 0) begin
            // One burst in four runs straight on into the next.
            gap_due = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap_due != 0) begin
                s_axis_tvalid <= 1'b0;
            end
        end
    endtask

    // Stops the sender, waits for every outstanding result and then lets the
    // block finish any window scan still running for a sample without tlast.
    // A pending gap means valid has already been lowered in this step.
    task automatic drain();
        if (gap_due == 0) begin
            s_axis_tvalid <= 1'b0;
        end
        burst_left = 0;
        gap_due    = 0;
        while (spreads.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(t_cfg value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        spreads.note_config(value);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_sample random_sample();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 15);
            3: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    // One phase: settle, pick a window length, send a few sequences. Now and
    // then a phase leaves a sequence open, so that the next phase changes the
    // window length part way through it.
    task automatic random_phase();
        t_cfg        len_cfg;
        int unsigned len_eff;
        int unsigned seq_count;
        int unsigned seq_len;
        case ($urandom_range(0, 9))
            0: len_cfg = 0;
            1: len_cfg = 1;
            2: len_cfg = t_cfg'(WINDOW_DEPTH);
            3: len_cfg = t_cfg'($urandom_range(WINDOW_DEPTH + 1, 127));
            default: len_cfg = t_cfg'($urandom_range(2, 16));
        endcase
        len_eff = (len_cfg == 0) ? 1 : ((len_cfg > WINDOW_DEPTH) ? WINDOW_DEPTH : len_cfg);
        drain();
        write_window(len_cfg);
        seq_count = $urandom_range(1, 4);
        repeat (seq_count) begin
            // Mostly sequences that reach or just exceed the window; some short ones
            // that at most fill it and some of up to 100 samples that can wrap the store.
            case ($urandom_range(0, 7))
                0: seq_len = $urandom_range(1, 100);
                1: seq_len = $urandom_range(1, len_eff);
                default: seq_len = $urandom_range(len_eff, len_eff + 10);
            endcase
            for (int i = 0; i < seq_len; i++) begin
                push_sample(random_sample(), i == seq_len - 1);
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, len_eff)) push_sample(random_sample(), 1'b0);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Window of one straight out of reset: each window holds a single sample,
        // so even the extremes of the sample range give zero, as does a lone sample.
        push_sample('0, 1'b0);
        push_sample('1, 1'b1);
        push_sample(32'd5, 1'b1);

        // A zero length behaves as a window of one.
        drain();
        write_window(0);
        push_sample(32'd7, 1'b0);
        push_sample(32'd3, 1'b1);

        // A sequence shorter than the window yields -1, then a normal one.
        drain();
        write_window(3);
        push_sample(32'd1, 1'b0);
        push_sample(32'd2, 1'b1);
        push_sample(32'd10, 1'b0);
        push_sample(32'd0, 1'b0);
        push_sample(32'd20, 1'b0);
        push_sample(32'd15, 1'b1);

        // All register bits set: the length is clamped to the store depth.
        drain();
        write_window(127);
        push_sample(32'd9, 1'b0);
        push_sample('1, 1'b0);
        push_sample('0, 1'b1);

        // Window length changed in the middle of a sequence.
        drain();
        write_window(2);
        push_sample(32'd100, 1'b0);
        push_sample(32'd50, 1'b0);
        drain();
        write_window(4);
        push_sample(32'd60, 1'b0);
        push_sample(32'd70, 1'b1);

        samples_base = sent_samples;
        lasts_base   = sent_lasts;
        while (sent_samples - samples_base < RANDOM_ITEMS ||
               sent_lasts - lasts_base < RANDOM_SEQS) begin
            random_phase();
        end

        drain();
        if (spreads.errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
